// File: rtl/mmhq_pkg.sv
// ----------------------------------------------------------------------------
// mmhq_pkg
// Shared widths, codes and types of the min-max heap queue.
// ----------------------------------------------------------------------------
package mmhq_pkg;

  localparam int DATA_W           = 32;
  localparam int COUNT_W          = 7;
  localparam int STATUS_W         = 2;
  localparam int DEFAULT_CAPACITY = 127;

  localparam int OUT_FIELDS_W = 3 * DATA_W + COUNT_W + STATUS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic                     start;
    logic                     op;
    logic signed [DATA_W-1:0] value;
  } req_t;

  // packed lowest field last so that it lands in the lowest bits
  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic        [COUNT_W-1:0]  entry_count;
    logic signed [DATA_W-1:0]   max_value;
    logic signed [DATA_W-1:0]   min_value;
    logic signed [DATA_W-1:0]   removed_value;
  } result_t;

  typedef struct packed {
    logic    ready;
    logic    done;
    result_t result;
  } rsp_t;

endpackage

// File: rtl/mmhq_core.sv
// ----------------------------------------------------------------------------
// mmhq_core
// Heap storage and the sequencer that sifts one word up or down, one memory
// read and one compare per cycle.
// ----------------------------------------------------------------------------
module mmhq_core #(
  parameter int CAPACITY = mmhq_pkg::DEFAULT_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  input  mmhq_pkg::req_t req,
  input  logic          res_take,
  output mmhq_pkg::rsp_t rsp
);
  import mmhq_pkg::*;

  localparam int AW = $clog2(CAPACITY + 1);
  localparam int WW = AW + 3;
  localparam logic [AW-1:0] CAP = AW'(CAPACITY);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_INS_PAR = 10'b0000000010,
    ST_UP_RD   = 10'b0000000100,
    ST_UP_CMP  = 10'b0000001000,
    ST_DEL_RD  = 10'b0000010000,
    ST_DN_SCAN = 10'b0000100000,
    ST_DN_DEC  = 10'b0001000000,
    ST_DN_PAR  = 10'b0010000000,
    ST_FIN     = 10'b0100000000,
    ST_DONE    = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0] count, count_next;
  logic [AW-1:0] idx, idx_next;
  logic [AW-1:0] best_addr, best_addr_next;
  logic [AW-1:0] paddr, paddr_next;
  logic signed [DATA_W-1:0] x, x_next;
  logic signed [DATA_W-1:0] best, best_next;
  logic signed [DATA_W-1:0] c0v, c0v_next;
  logic signed [DATA_W-1:0] c1v, c1v_next;
  logic signed [DATA_W-1:0] removed, removed_next;
  logic [STATUS_W-1:0] status, status_next;
  logic max_mode, max_mode_next;
  logic [2:0] k, k_next;
  logic [2:0] pk, pk_next;
  logic [2:0] best_k, best_k_next;
  logic pend, pend_next;
  logic any, any_next;

  logic signed [DATA_W-1:0] mem [CAPACITY+1];
  logic signed [DATA_W-1:0] rdata;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     we;

  logic signed [DATA_W-1:0] sh1, sh2, sh3;

  logic [AW-1:0]            ev_bits, od_bits;
  logic                     min_lvl;
  logic [WW-1:0]            cand;
  logic                     issue;
  logic signed [DATA_W-1:0] pv;
  logic [AW+6:0]            count_ext;

  // min level when the top set bit sits at an even position
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      ev_bits[b] = idx[b] & ~b[0];
      od_bits[b] = idx[b] & b[0];
    end
    min_lvl = ev_bits > od_bits;
  end

  // children then grandchildren of idx, in ascending order
  always_comb begin
    if (k < 3'd2) begin
      cand = (WW'(idx) << 1) | WW'(k[0]);
    end else begin
      cand = (WW'(idx) << 2) + WW'(2'(k - 3'd2));
    end
  end

  assign issue = (k < 3'd6) && (cand <= WW'(count));
  assign pv    = best_k[2] ? c1v : c0v;

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    best_addr_next = best_addr;
    paddr_next     = paddr;
    x_next         = x;
    best_next      = best;
    c0v_next       = c0v;
    c1v_next       = c1v;
    removed_next   = removed;
    status_next    = status;
    max_mode_next  = max_mode;
    k_next         = k;
    pk_next        = pk;
    best_k_next    = best_k;
    pend_next      = pend;
    any_next       = any;
    rd_addr        = idx;
    we             = 1'b0;
    wr_addr        = idx;
    wr_data        = x;

    unique case (state)
      ST_IDLE: begin
        if (req.start) begin
          status_next  = STATUS_OK;
          removed_next = '0;
          if (req.op == OP_INSERT) begin
            if (count == CAP) begin
              status_next = STATUS_FULL;
              state_next  = ST_DONE;
            end else begin
              count_next = count + AW'(1);
              idx_next   = count + AW'(1);
              x_next     = req.value;
              if (count == '0) begin
                state_next = ST_FIN;
              end else begin
                rd_addr    = (count + AW'(1)) >> 1;
                state_next = ST_INS_PAR;
              end
            end
          end else begin
            if (count == '0) begin
              status_next = STATUS_EMPTY;
              state_next  = ST_DONE;
            end else begin
              removed_next = sh1;
              rd_addr      = count;
              count_next   = count - AW'(1);
              state_next   = ST_DEL_RD;
            end
          end
        end
      end

      ST_INS_PAR: begin
        if (min_lvl ? (x > rdata) : (x < rdata)) begin
          we            = 1'b1;
          wr_data       = rdata;
          idx_next      = idx >> 1;
          max_mode_next = min_lvl;
        end else begin
          max_mode_next = ~min_lvl;
        end
        state_next = ST_UP_RD;
      end

      ST_UP_RD: begin
        if ((idx >> 2) == '0) begin
          state_next = ST_FIN;
        end else begin
          rd_addr    = idx >> 2;
          state_next = ST_UP_CMP;
        end
      end

      ST_UP_CMP: begin
        if (max_mode ? (x > rdata) : (x < rdata)) begin
          we         = 1'b1;
          wr_data    = rdata;
          idx_next   = idx >> 2;
          state_next = ST_UP_RD;
        end else begin
          state_next = ST_FIN;
        end
      end

      ST_DEL_RD: begin
        x_next = rdata;
        if (count == '0) begin
          state_next = ST_DONE;
        end else begin
          idx_next   = AW'(1);
          k_next     = '0;
          pend_next  = 1'b0;
          any_next   = 1'b0;
          state_next = ST_DN_SCAN;
        end
      end

      ST_DN_SCAN: begin
        pend_next = issue;
        if (issue) begin
          rd_addr    = cand[AW-1:0];
          paddr_next = cand[AW-1:0];
          pk_next    = k;
          k_next     = k + 3'd1;
        end else begin
          k_next = 3'd6;
        end
        if (pend) begin
          any_next = 1'b1;
          if (pk == 3'd0) begin
            best_next      = rdata;
            best_addr_next = paddr;
            best_k_next    = pk;
            c0v_next       = rdata;
          end else begin
            if (pk == 3'd1) begin
              c1v_next = rdata;
            end
            if (rdata < best) begin
              best_next      = rdata;
              best_addr_next = paddr;
              best_k_next    = pk;
            end
          end
        end
        if (!issue && !pend) begin
          state_next = ST_DN_DEC;
        end
      end

      ST_DN_DEC: begin
        if (!any || !(best < x)) begin
          state_next = ST_FIN;
        end else begin
          we      = 1'b1;
          wr_data = best;
          if (best_k < 3'd2) begin
            idx_next   = best_addr;
            state_next = ST_FIN;
          end else if (x > pv) begin
            state_next = ST_DN_PAR;
          end else begin
            idx_next   = best_addr;
            k_next     = '0;
            pend_next  = 1'b0;
            any_next   = 1'b0;
            state_next = ST_DN_SCAN;
          end
        end
      end

      ST_DN_PAR: begin
        we         = 1'b1;
        wr_addr    = best_addr >> 1;
        wr_data    = x;
        x_next     = pv;
        idx_next   = best_addr;
        k_next     = '0;
        pend_next  = 1'b0;
        any_next   = 1'b0;
        state_next = ST_DN_SCAN;
      end

      ST_FIN: begin
        we         = 1'b1;
        state_next = ST_DONE;
      end

      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    best_addr <= best_addr_next;
    paddr     <= paddr_next;
    x         <= x_next;
    best      <= best_next;
    c0v       <= c0v_next;
    c1v       <= c1v_next;
    removed   <= removed_next;
    status    <= status_next;
    max_mode  <= max_mode_next;
    k         <= k_next;
    pk        <= pk_next;
    best_k    <= best_k_next;
    pend      <= pend_next;
    any       <= any_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  // copies of the top three slots for min and max
  always_ff @(posedge clk) begin
    if (we) begin
      if (wr_addr == AW'(1)) begin
        sh1 <= wr_data;
      end
      if (wr_addr == AW'(2)) begin
        sh2 <= wr_data;
      end
      if (wr_addr == AW'(3)) begin
        sh3 <= wr_data;
      end
    end
  end

  assign count_ext = (AW + 7)'(count);

  always_comb begin
    rsp.ready                = (state == ST_IDLE);
    rsp.done                 = (state == ST_DONE);
    rsp.result.status        = status;
    rsp.result.entry_count   = count_ext[COUNT_W-1:0];
    rsp.result.removed_value = removed;
    rsp.result.min_value     = '0;
    rsp.result.max_value     = '0;
    if (count != '0) begin
      rsp.result.min_value = sh1;
      rsp.result.max_value = sh1;
    end
    if (count == AW'(2)) begin
      rsp.result.max_value = sh2;
    end else if (count > AW'(2)) begin
      rsp.result.max_value = (sh2 > sh3) ? sh2 : sh3;
    end
  end

endmodule

// File: rtl/min_max_heap_queue.sv
// a refused word goes straight to the result; an insert into empty just writes the word
// insert: a parent compare, then one read and one compare per grandparent swap up the heap
// delete: a read of the last word, then per level visited a scan of the children and
// grandchildren and a decide step, plus a grandchild-parent swap step where one is needed
// one word at a time: the next word is accepted only once the result has entered the output register
// rst clears the count, sequencer and output valid; heap memory is not cleared
// ----------------------------------------------------------------------------
// min_max_heap_queue
// Min-max heap priority queue with insert and delete-min over stream ports.
// ----------------------------------------------------------------------------
module min_max_heap_queue #(
  parameter int CAPACITY = mmhq_pkg::DEFAULT_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mmhq_pkg::DATA_W-1:0]      s_tdata,  // value
  input  logic                             s_tuser,  // op
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // removed_value, min_value, max_value, entry_count, status, zero pad
  output logic [mmhq_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import mmhq_pkg::*;

  req_t    req;
  rsp_t    rsp;
  logic    take;
  result_t out_res;

  assign req.start = s_tvalid & s_tready;
  assign req.op    = s_tuser;
  assign req.value = s_tdata;
  assign s_tready  = rsp.ready;

  assign take = rsp.done & (~m_tvalid | m_tready);

  mmhq_core #(
    .CAPACITY(CAPACITY)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res_take (take),
    .rsp      (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res <= rsp.result;
    end
  end

  assign m_tdata = OUT_TDATA_W'(out_res);

endmodule

// File: rtl/mmhq_checker.sv
// ----------------------------------------------------------------------------
// mmhq_checker
// Port-level checks on the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module mmhq_checker #(
  parameter int CAPACITY = mmhq_pkg::DEFAULT_CAPACITY
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [mmhq_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import mmhq_pkg::*;

  logic signed [DATA_W-1:0] removed_w, min_w, max_w;
  logic [COUNT_W-1:0]       count_w;
  logic [STATUS_W-1:0]      status_w;

  assign removed_w = m_tdata[DATA_W-1:0];
  assign min_w     = m_tdata[2*DATA_W-1:DATA_W];
  assign max_w     = m_tdata[3*DATA_W-1:2*DATA_W];
  assign count_w   = m_tdata[3*DATA_W+COUNT_W-1:3*DATA_W];
  assign status_w  = m_tdata[3*DATA_W+COUNT_W+STATUS_W-1:3*DATA_W+COUNT_W];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while busy");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && count_w != '0 |-> min_w <= max_w)
    else $error("minimum above maximum");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status_w == STATUS_EMPTY |-> count_w == '0 && removed_w == '0)
    else $error("empty delete with entries or a removed value");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status_w == STATUS_FULL |-> count_w == COUNT_W'(CAPACITY))
    else $error("full insert below capacity");

endmodule

bind min_max_heap_queue mmhq_checker #(.CAPACITY(CAPACITY)) u_mmhq_checker (.*);
